FILE: hdl/char_lcd_write_sequencer_top_assert.svh
// Assertion macros for the character LCD write sequencer checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef CHAR_LCD_WRITE_SEQUENCER_TOP_ASSERT_SVH
`define CHAR_LCD_WRITE_SEQUENCER_TOP_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define LCDWS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define LCDWS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/lcdws_pkg.sv
// Shared types and constants for the character LCD write sequencer.
// No dependencies.
`timescale 1ns / 1ps

package lcdws_pkg;

  typedef enum logic [2:0] {
    ACT_INIT    = 3'd0,
    ACT_COMMAND = 3'd1,
    ACT_CHAR    = 3'd2,
    ACT_CURSOR  = 3'd3,
    ACT_CLEAR   = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    REG_EIGHT_BIT    = 3'd0,
    REG_FUNCTION_SET = 3'd1,
    REG_DISPLAY_ON   = 3'd2,
    REG_ENTRY_MODE   = 3'd3,
    REG_CLEAR        = 3'd4
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POWER_WAIT,
    ST_SEND
  } state_e;

  typedef struct packed {
    logic       eight_bit_bus;
    logic [7:0] function_set_code;
    logic [7:0] display_on_code;
    logic [7:0] entry_mode_code;
    logic [7:0] clear_code;
  } cfg_t;

  typedef struct packed {
    logic       is_init;
    logic       rs;
    logic [7:0] value;
  } entry_t;

  localparam logic [15:0] HOLD_PULSE_HIGH = 16'd1000;
  localparam logic [15:0] HOLD_PULSE_LOW  = 16'd2000;
  localparam logic [15:0] HOLD_SETUP_LAST = 16'd2040;
  localparam logic [15:0] HOLD_CLEAR_LAST = 16'd4000;
  localparam logic [15:0] HOLD_POWER_WAIT = 16'd40000;

  localparam logic [7:0] ADDR_ROW0 = 8'h80;
  localparam logic [7:0] ADDR_ROW1 = 8'hC0;

  localparam logic [7:0] RST_FUNCTION_SET = 8'd40;
  localparam logic [7:0] RST_DISPLAY_ON   = 8'd12;
  localparam logic [7:0] RST_ENTRY_MODE   = 8'd6;
  localparam logic [7:0] RST_CLEAR        = 8'd1;

endpackage

FILE: hdl/lcdws_front.sv
// Front end: accepts requests; each known action becomes one queue entry.
// Depends on lcdws_pkg.
`timescale 1ns / 1ps

module lcdws_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lcdws_pkg::cfg_t       cfg_i,
  input  logic                  push_i,
  output logic                  full_o,
  input  logic [2:0]            action_i,
  input  logic [7:0]            byte_value_i,
  input  logic                  row_i,
  input  logic [4:0]            column_i,
  output logic                  q_push_o,
  output lcdws_pkg::entry_t     q_data_o,
  input  logic                  q_ready_i
);

  logic              valid_q;
  logic              valid_d;
  lcdws_pkg::entry_t entry_q;
  lcdws_pkg::entry_t entry_d;
  logic              act_ok;
  logic              accept;
  logic [7:0]        cursor_addr;

  assign full_o   = valid_q && !q_ready_i;
  assign accept   = push_i && !full_o;
  assign q_push_o = valid_q;
  assign q_data_o = entry_q;

  always_comb begin
    cursor_addr = row_i ? lcdws_pkg::ADDR_ROW1 : lcdws_pkg::ADDR_ROW0;
    if (!column_i[4]) begin
      cursor_addr[3:0] = column_i[3:0];
    end
  end

  always_comb begin
    act_ok          = 1'b1;
    entry_d.is_init = 1'b0;
    entry_d.rs      = 1'b0;
    entry_d.value   = byte_value_i;
    case (action_i)
      lcdws_pkg::ACT_INIT: begin
        entry_d.is_init = 1'b1;
        entry_d.value   = 8'd0;
      end
      lcdws_pkg::ACT_COMMAND: begin
        entry_d.value = byte_value_i;
      end
      lcdws_pkg::ACT_CHAR: begin
        entry_d.rs = 1'b1;
      end
      lcdws_pkg::ACT_CURSOR: begin
        entry_d.value = cursor_addr;
      end
      lcdws_pkg::ACT_CLEAR: begin
        entry_d.value = cfg_i.clear_code;
      end
      default: begin
        act_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = act_ok;
    end else if (valid_q && q_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      entry_q <= entry_d;
    end
  end

endmodule

FILE: hdl/lcdws_queue.sv
// Short queue of classified requests between the front and back ends.
// Depends on lcdws_pkg.
`timescale 1ns / 1ps

module lcdws_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  lcdws_pkg::entry_t data_i,
  output logic              ready_o,
  input  logic              pop_i,
  output logic              valid_o,
  output lcdws_pkg::entry_t data_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  lcdws_pkg::entry_t entries_q [DEPTH];
  logic [AW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]     count_q, count_d;
  logic              do_push;
  logic              do_pop;

  assign ready_o = (count_q != FULL_CNT);
  assign valid_o = (count_q != '0);
  assign data_o  = entries_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: hdl/lcdws_back.sv
// Back end: expands queued requests into pin steps in an output register,
// one per cycle while that register is empty or being popped. Depends on lcdws_pkg.
`timescale 1ns / 1ps

module lcdws_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lcdws_pkg::cfg_t   cfg_i,
  input  logic              q_valid_i,
  input  lcdws_pkg::entry_t q_data_i,
  output logic              q_pop_o,
  input  logic              pop_i,
  output logic              empty_o,
  output logic              register_select_o,
  output logic [7:0]        bus_value_o,
  output logic              enable_level_o,
  output logic [15:0]       hold_us_o,
  output logic              last_step_o
);

  lcdws_pkg::state_e state_q, state_d;
  lcdws_pkg::entry_t entry_q;
  logic [1:0]        sub_q, sub_d;
  logic [1:0]        byte_sel_q, byte_sel_d;
  logic              out_valid_q, out_valid_d;
  logic              out_free;
  logic              step_fire;
  logic              sub_last;
  logic              req_last;
  logic              done;
  logic [7:0]        init_code;
  logic [7:0]        byte_val;
  logic              st_rs;
  logic [7:0]        st_bus;
  logic              st_en;
  logic [15:0]       st_hold;
  logic              st_last;

  assign out_free  = !out_valid_q || pop_i;
  assign step_fire = (state_q != lcdws_pkg::ST_IDLE) && out_free;
  assign sub_last  = cfg_i.eight_bit_bus ? (sub_q == 2'd1) : (sub_q == 2'd3);
  assign req_last  = sub_last && (!entry_q.is_init || (byte_sel_q == 2'd3));
  assign done      = step_fire && (state_q == lcdws_pkg::ST_SEND) && req_last;
  assign q_pop_o   = q_valid_i && ((state_q == lcdws_pkg::ST_IDLE) || done);
  assign empty_o   = !out_valid_q;

  // Next state and step counters.
  always_comb begin
    state_d    = state_q;
    sub_d      = sub_q;
    byte_sel_d = byte_sel_q;
    if (q_pop_o) begin
      state_d    = q_data_i.is_init ? lcdws_pkg::ST_POWER_WAIT : lcdws_pkg::ST_SEND;
      sub_d      = 2'd0;
      byte_sel_d = 2'd0;
    end else if (done) begin
      state_d = lcdws_pkg::ST_IDLE;
    end else if (step_fire && (state_q == lcdws_pkg::ST_POWER_WAIT)) begin
      state_d    = lcdws_pkg::ST_SEND;
      sub_d      = 2'd0;
      byte_sel_d = 2'd0;
    end else if (step_fire) begin
      if (sub_last) begin
        sub_d      = 2'd0;
        byte_sel_d = byte_sel_q + 2'd1;
      end else begin
        sub_d = sub_q + 2'd1;
      end
    end
  end

  // Pin levels of the current step.
  always_comb begin
    case (byte_sel_q)
      2'd0:    init_code = cfg_i.function_set_code;
      2'd1:    init_code = cfg_i.display_on_code;
      2'd2:    init_code = cfg_i.entry_mode_code;
      default: init_code = cfg_i.clear_code;
    endcase
    byte_val = entry_q.is_init ? init_code : entry_q.value;
    st_rs    = entry_q.rs;
    st_en    = !sub_q[0];
    if (cfg_i.eight_bit_bus) begin
      st_bus = byte_val;
    end else if (sub_q[1]) begin
      st_bus = {byte_val[3:0], 4'b0000};
    end else begin
      st_bus = {byte_val[7:4], 4'b0000};
    end
    if (st_en) begin
      st_hold = lcdws_pkg::HOLD_PULSE_HIGH;
    end else if (sub_last && entry_q.is_init) begin
      st_hold = (byte_sel_q == 2'd3) ? lcdws_pkg::HOLD_CLEAR_LAST
                                     : lcdws_pkg::HOLD_SETUP_LAST;
    end else begin
      st_hold = lcdws_pkg::HOLD_PULSE_LOW;
    end
    st_last = req_last;
    case (state_q)
      lcdws_pkg::ST_POWER_WAIT: begin
        st_rs   = 1'b0;
        st_bus  = 8'd0;
        st_en   = 1'b0;
        st_hold = lcdws_pkg::HOLD_POWER_WAIT;
        st_last = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (step_fire) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lcdws_pkg::ST_IDLE;
      sub_q       <= 2'd0;
      byte_sel_q  <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sub_q       <= sub_d;
      byte_sel_q  <= byte_sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      entry_q <= q_data_i;
    end
    if (step_fire) begin
      register_select_o <= st_rs;
      bus_value_o       <= st_bus;
      enable_level_o    <= st_en;
      hold_us_o         <= st_hold;
      last_step_o       <= st_last;
    end
  end

endmodule

FILE: hdl/char_lcd_write_sequencer_top.sv
// Top level of the character LCD write sequencer: configuration registers,
// front end, request queue and step generator. Depends on lcdws_pkg.
// Request path: front-end register, queue, state register, output register.
// Throughput: one pin step per cycle while the output register is empty or
// popped; the queue takes one request a cycle while it is not full.
// Reset: asynchronous active low; queue and front-end register empty, configuration registers at their defaults.
`timescale 1ns / 1ps

module char_lcd_write_sequencer_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  action_i,
  input  logic [7:0]  byte_value_i,
  input  logic        row_i,
  input  logic [4:0]  column_i,
  output logic        empty,
  input  logic        pop,
  output logic        register_select_o,
  output logic [7:0]  bus_value_o,
  output logic        enable_level_o,
  output logic [15:0] hold_us_o,
  output logic        last_step_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  lcdws_pkg::cfg_t   cfg_q;
  lcdws_pkg::entry_t fq_data;
  lcdws_pkg::entry_t qb_data;
  logic              fq_push;
  logic              fq_ready;
  logic              qb_valid;
  logic              qb_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.eight_bit_bus     <= 1'b0;
      cfg_q.function_set_code <= lcdws_pkg::RST_FUNCTION_SET;
      cfg_q.display_on_code   <= lcdws_pkg::RST_DISPLAY_ON;
      cfg_q.entry_mode_code   <= lcdws_pkg::RST_ENTRY_MODE;
      cfg_q.clear_code        <= lcdws_pkg::RST_CLEAR;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        lcdws_pkg::REG_EIGHT_BIT:    cfg_q.eight_bit_bus     <= cfg_data_i[0];
        lcdws_pkg::REG_FUNCTION_SET: cfg_q.function_set_code <= cfg_data_i;
        lcdws_pkg::REG_DISPLAY_ON:   cfg_q.display_on_code   <= cfg_data_i;
        lcdws_pkg::REG_ENTRY_MODE:   cfg_q.entry_mode_code   <= cfg_data_i;
        lcdws_pkg::REG_CLEAR:        cfg_q.clear_code        <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  lcdws_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .push_i       (push),
    .full_o       (full),
    .action_i     (action_i),
    .byte_value_i (byte_value_i),
    .row_i        (row_i),
    .column_i     (column_i),
    .q_push_o     (fq_push),
    .q_data_o     (fq_data),
    .q_ready_i    (fq_ready)
  );

  lcdws_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_push),
    .data_i  (fq_data),
    .ready_o (fq_ready),
    .pop_i   (qb_pop),
    .valid_o (qb_valid),
    .data_o  (qb_data)
  );

  lcdws_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .q_valid_i         (qb_valid),
    .q_data_i          (qb_data),
    .q_pop_o           (qb_pop),
    .pop_i             (pop),
    .empty_o           (empty),
    .register_select_o (register_select_o),
    .bus_value_o       (bus_value_o),
    .enable_level_o    (enable_level_o),
    .hold_us_o         (hold_us_o),
    .last_step_o       (last_step_o)
  );

endmodule

FILE: hdl/lcdws_checker.sv
// Port-level checker for the character LCD write sequencer, bound to the
// top level. Depends on char_lcd_write_sequencer_top_assert.svh.
`timescale 1ns / 1ps
`include "char_lcd_write_sequencer_top_assert.svh"

module lcdws_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [7:0]  bus_value_o,
  input logic        enable_level_o,
  input logic [15:0] hold_us_o,
  input logic        last_step_o
);

  `LCDWS_ASSERT_NEXT(a_out_hold, !empty && !pop, !empty && $stable(bus_value_o) && $stable(hold_us_o), "Waiting item changed before it was taken.")
  `LCDWS_ASSERT_NOW(a_high_hold, !empty && enable_level_o, hold_us_o == 16'd1000, "Enable high step without the pulse width.")
  `LCDWS_ASSERT_NOW(a_low_hold, !empty && !enable_level_o, hold_us_o == 16'd2000 || hold_us_o == 16'd2040 || hold_us_o == 16'd4000 || hold_us_o == 16'd40000, "Enable low step with a bad hold time.")
  `LCDWS_ASSERT_NOW(a_last_low, !empty && last_step_o, !enable_level_o, "Final step leaves enable high.")

endmodule

bind char_lcd_write_sequencer_top lcdws_checker u_lcdws_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .empty          (empty),
  .pop            (pop),
  .bus_value_o    (bus_value_o),
  .enable_level_o (enable_level_o),
  .hold_us_o      (hold_us_o),
  .last_step_o    (last_step_o)
);
